FILE: design/scaled_text_glyph_renderer_core_defines.svh
// assertion macros shared by the checker files
// expects clk and rst_n in the scope where a macro is used
`ifndef SCALED_TEXT_GLYPH_RENDERER_CORE_DEFINES_SVH
`define SCALED_TEXT_GLYPH_RENDERER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define STGR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define STGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/stgr_pkg.sv
// shared types, geometry constants and 5x7 font table for the glyph renderer
// no dependencies
package stgr_pkg;

    localparam int DISPLAY_WIDTH  = 72;
    localparam int DISPLAY_HEIGHT = 40;
    localparam int MAX_LINE_CHARS = 6;

    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    localparam int SLOT_PITCH = 12;
    localparam int ROW_PITCH  = 20;
    localparam int TOP_MARGIN = 3;
    localparam int CELL_WIDTH = 10;
    localparam int GLYPH_COLS = 5;
    localparam int FIRST_CODE = 32;
    localparam int LAST_CODE  = 90;

    // a glyph cell of 14 rows spans at most three pages
    localparam int DRAW_PAGES = 3;

    // widths of internal coordinates and counters
    localparam int COORD_W = 9;
    localparam int PAGE_W  = 4;
    localparam int CCNT_W  = 4;
    localparam int FONT_W  = GLYPH_COLS * 8;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic       text_row;
        logic [2:0] char_slot;
        logic [2:0] line_length;
        logic [7:0] char_code;
        logic [2:0] page_index;
        logic [6:0] column_index;
    } in_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       request_ignored;
    } out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PREP,
        ST_CLEAR,
        ST_DRAW,
        ST_FLUSH,
        ST_RDWAIT,
        ST_RESULT
    } state_t;

    // font columns packed with column 0 in the low byte, bit 0 is the top row
    function automatic logic [FONT_W-1:0] glyph_bits(input logic [5:0] idx);
        logic [FONT_W-1:0] g;
        case (idx)
            6'd1:    g = 40'h00_00_5F_00_00;
            6'd13:   g = 40'h08_08_08_08_08;
            6'd14:   g = 40'h00_00_60_60_00;
            6'd15:   g = 40'h02_04_08_10_20;
            6'd16:   g = 40'h3E_45_49_51_3E;
            6'd17:   g = 40'h00_40_7F_42_00;
            6'd18:   g = 40'h46_49_51_61_42;
            6'd19:   g = 40'h31_4B_45_41_21;
            6'd20:   g = 40'h10_7F_12_14_18;
            6'd21:   g = 40'h39_45_45_45_27;
            6'd22:   g = 40'h30_49_49_4A_3C;
            6'd23:   g = 40'h03_05_09_71_01;
            6'd24:   g = 40'h36_49_49_49_36;
            6'd25:   g = 40'h1E_29_49_49_06;
            6'd26:   g = 40'h00_00_36_36_00;
            6'd31:   g = 40'h06_09_51_01_02;
            6'd33:   g = 40'h7E_11_11_11_7E;
            6'd34:   g = 40'h36_49_49_49_7F;
            6'd35:   g = 40'h22_41_41_41_3E;
            6'd36:   g = 40'h1C_22_41_41_7F;
            6'd37:   g = 40'h41_49_49_49_7F;
            6'd38:   g = 40'h01_09_09_09_7F;
            6'd39:   g = 40'h7A_49_49_41_3E;
            6'd40:   g = 40'h7F_08_08_08_7F;
            6'd41:   g = 40'h00_41_7F_41_00;
            6'd42:   g = 40'h01_3F_41_40_20;
            6'd43:   g = 40'h41_22_14_08_7F;
            6'd44:   g = 40'h40_40_40_40_7F;
            6'd45:   g = 40'h7F_02_0C_02_7F;
            6'd46:   g = 40'h7F_10_08_04_7F;
            6'd47:   g = 40'h3E_41_41_41_3E;
            6'd48:   g = 40'h06_09_09_09_7F;
            6'd49:   g = 40'h5E_21_51_41_3E;
            6'd50:   g = 40'h46_29_19_09_7F;
            6'd51:   g = 40'h31_49_49_49_46;
            6'd52:   g = 40'h01_01_7F_01_01;
            6'd53:   g = 40'h3F_40_40_40_3F;
            6'd54:   g = 40'h1F_20_40_20_1F;
            6'd55:   g = 40'h3F_40_38_40_3F;
            6'd56:   g = 40'h63_14_08_14_63;
            6'd57:   g = 40'h07_08_70_08_07;
            6'd58:   g = 40'h43_45_49_51_61;
            default: g = '0;
        endcase
        return g;
    endfunction

    // rows of a page that lie inside the display height
    function automatic logic [7:0] page_mask(input logic [PAGE_W-1:0] page);
        logic [7:0] m;
        for (int b = 0; b < 8; b++) begin
            m[b] = ((int'(page) * 8 + b) < DISPLAY_HEIGHT);
        end
        return m;
    endfunction

endpackage

FILE: design/stgr_ram.sv
// generic single write port, single read port RAM with registered read
// no dependencies
module stgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/scaled_text_glyph_renderer_core.sv
// top level of the scaled text glyph renderer: sequencer, frame store, result register
// depends on stgr_pkg and stgr_ram
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------
//   in      | into      | in_valid/in_stall  | in_data   (in_t)
//   out     | out of    | out_valid/out_stall| out_data  (out_t)
//   cfg     | into      | cfg_valid/cfg_ready| cfg_data  (display ready bit)
//
// after reset all STORE_BYTES addresses of the store are swept to zero, in_stall high meanwhile
// clear: one store byte a cycle in ST_CLEAR, between ST_PREP and ST_RESULT
// draw: one read-modify-write per cycle on the store port, 10 columns x 3 pages, then ST_FLUSH
// read: ST_PREP, ST_RDWAIT, ST_RESULT; ignored requests ST_PREP, ST_RESULT; next input taken in ST_IDLE
// the result register lets the next item be taken while a result waits on out_stall
module scaled_text_glyph_renderer_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  stgr_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output stgr_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);

    localparam int AW = stgr_pkg::ADDR_W;
    localparam int CW = stgr_pkg::COORD_W;
    localparam int PW = stgr_pkg::PAGE_W;

    // each font bit becomes two rows
    function automatic logic [13:0] double_rows(input logic [6:0] bits);
        logic [13:0] d;
        for (int i = 0; i < 7; i++)
        begin
            d[2*i]     = bits[i];
            d[2*i + 1] = bits[i];
        end
        return d;
    endfunction

    stgr_pkg::state_t state_reg, state_next;
    stgr_pkg::in_t    item_reg, item_next;
    stgr_pkg::out_t   out_data_reg, out_data_next;

    logic                          ready_reg;
    logic [AW-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]                 x0_reg, x0_next;
    logic [PW-1:0]                 ybase_reg, ybase_next;
    logic [2:0]                    yoff_reg, yoff_next;
    logic [stgr_pkg::FONT_W-1:0]   font_reg, font_next;
    logic [stgr_pkg::CCNT_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [1:0]                    pg_cnt_reg, pg_cnt_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [AW-1:0]                 pend_addr_reg, pend_addr_next;
    logic [7:0]                    pend_mask_reg, pend_mask_next;
    logic [7:0]                    res_byte_reg, res_byte_next;
    logic                          res_ign_reg, res_ign_next;
    logic                          out_valid_reg, out_valid_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // request decode
    logic [2:0]    len_c;
    logic [CW-1:0] line_px;
    logic [CW-1:0] x0_calc;
    logic [CW-1:0] y0_calc;
    logic          geom_ok;
    logic [7:0]    code_f;
    logic          code_ok;
    logic [5:0]    glyph_idx;
    logic          rd_ok;
    logic [AW-1:0] rd_addr_calc;

    // draw step
    logic [7:0]    step_font;
    logic [23:0]   step_win;
    logic [7:0]    step_byte;
    logic [PW-1:0] step_page;
    logic          step_page_ok;
    logic [CW-1:0] step_px;
    logic [AW-1:0] step_addr;
    logic          step_last;
    logic          out_load;

    assign in_stall  = (state_reg != stgr_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    stgr_ram #(
        .WIDTH(8),
        .DEPTH(stgr_pkg::STORE_BYTES)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // line geometry, glyph selection and read address for the held request
    always_comb
    begin
        len_c = (item_reg.line_length > 3'(stgr_pkg::MAX_LINE_CHARS))
              ? 3'(stgr_pkg::MAX_LINE_CHARS) : item_reg.line_length;
        line_px = CW'(len_c) * CW'(stgr_pkg::SLOT_PITCH) - CW'(2);
        x0_calc = ((CW'(stgr_pkg::DISPLAY_WIDTH) - line_px) >> 1)
                + CW'(item_reg.char_slot) * CW'(stgr_pkg::SLOT_PITCH);
        geom_ok = (item_reg.char_slot < len_c)
               && (line_px <= CW'(stgr_pkg::DISPLAY_WIDTH))
               && (x0_calc + CW'(stgr_pkg::CELL_WIDTH) <= CW'(stgr_pkg::DISPLAY_WIDTH));
        y0_calc = item_reg.text_row ? CW'(stgr_pkg::TOP_MARGIN + stgr_pkg::ROW_PITCH)
                                    : CW'(stgr_pkg::TOP_MARGIN);

        // lower case folds to upper case
        if (item_reg.char_code inside {[8'h61:8'h7A]})
        begin
            code_f = item_reg.char_code - 8'd32;
        end
        else
        begin
            code_f = item_reg.char_code;
        end
        code_ok   = (code_f >= 8'(stgr_pkg::FIRST_CODE)) && (code_f <= 8'(stgr_pkg::LAST_CODE));
        glyph_idx = 6'(code_f - 8'(stgr_pkg::FIRST_CODE));

        rd_ok = (int'(item_reg.page_index) < stgr_pkg::PAGE_COUNT)
             && (int'(item_reg.column_index) < stgr_pkg::DISPLAY_WIDTH);
        rd_addr_calc = AW'(item_reg.column_index)
                     + AW'(int'(item_reg.page_index) * stgr_pkg::DISPLAY_WIDTH);
    end

    // one store byte of the current glyph column
    always_comb
    begin
        step_font = font_reg[col_cnt_reg[stgr_pkg::CCNT_W-1:1] * 8 +: 8];
        step_win  = 24'(double_rows(step_font[6:0])) << yoff_reg;
        case (pg_cnt_reg)
            2'd0:    step_byte = step_win[7:0];
            2'd1:    step_byte = step_win[15:8];
            2'd2:    step_byte = step_win[23:16];
            default: step_byte = '0;
        endcase
        step_page    = ybase_reg + PW'(pg_cnt_reg);
        step_page_ok = (int'(step_page) < stgr_pkg::PAGE_COUNT);
        step_px      = x0_reg + CW'(col_cnt_reg);
        step_addr    = AW'(step_px) + AW'(int'(step_page) * stgr_pkg::DISPLAY_WIDTH);
        step_last    = (col_cnt_reg == stgr_pkg::CCNT_W'(stgr_pkg::CELL_WIDTH - 1))
                    && (pg_cnt_reg == 2'(stgr_pkg::DRAW_PAGES - 1));
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        clr_cnt_next    = clr_cnt_reg;
        x0_next         = x0_reg;
        ybase_next      = ybase_reg;
        yoff_next       = yoff_reg;
        font_next       = font_reg;
        col_cnt_next    = col_cnt_reg;
        pg_cnt_next     = pg_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_mask_next  = pend_mask_reg;
        res_byte_next   = res_byte_reg;
        res_ign_next    = res_ign_reg;
        out_load        = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata | pend_mask_reg;
        ram_raddr = step_addr;

        case (state_reg)
            stgr_pkg::ST_INIT,
            stgr_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == AW'(stgr_pkg::STORE_BYTES - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = (state_reg == stgr_pkg::ST_INIT) ? stgr_pkg::ST_IDLE
                                                                   : stgr_pkg::ST_RESULT;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            stgr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = stgr_pkg::ST_PREP;
                end
            end

            stgr_pkg::ST_PREP:
            begin
                res_byte_next   = '0;
                res_ign_next    = 1'b0;
                pend_valid_next = 1'b0;
                ram_raddr       = rd_addr_calc;
                case (item_reg.func)
                    stgr_pkg::FUNC_CLEAR:
                    begin
                        clr_cnt_next = '0;
                        if (ready_reg)
                        begin
                            state_next = stgr_pkg::ST_CLEAR;
                        end
                        else
                        begin
                            res_ign_next = 1'b1;
                            state_next   = stgr_pkg::ST_RESULT;
                        end
                    end
                    stgr_pkg::FUNC_DRAW:
                    begin
                        x0_next      = x0_calc;
                        ybase_next   = PW'(y0_calc >> 3);
                        yoff_next    = y0_calc[2:0];
                        font_next    = code_ok ? stgr_pkg::glyph_bits(glyph_idx) : '0;
                        col_cnt_next = '0;
                        pg_cnt_next  = '0;
                        if (ready_reg && geom_ok)
                        begin
                            state_next = stgr_pkg::ST_DRAW;
                        end
                        else
                        begin
                            res_ign_next = 1'b1;
                            state_next   = stgr_pkg::ST_RESULT;
                        end
                    end
                    stgr_pkg::FUNC_READ:
                    begin
                        if (rd_ok)
                        begin
                            state_next = stgr_pkg::ST_RDWAIT;
                        end
                        else
                        begin
                            res_ign_next = 1'b1;
                            state_next   = stgr_pkg::ST_RESULT;
                        end
                    end
                    default:
                    begin
                        res_ign_next = 1'b1;
                        state_next   = stgr_pkg::ST_RESULT;
                    end
                endcase
            end

            stgr_pkg::ST_DRAW:
            begin
                // read this byte while the previous one is written back
                ram_we          = pend_valid_reg;
                pend_valid_next = step_page_ok;
                pend_addr_next  = step_addr;
                pend_mask_next  = step_byte & stgr_pkg::page_mask(step_page);
                if (pg_cnt_reg == 2'(stgr_pkg::DRAW_PAGES - 1))
                begin
                    pg_cnt_next  = '0;
                    col_cnt_next = col_cnt_reg + stgr_pkg::CCNT_W'(1);
                end
                else
                begin
                    pg_cnt_next = pg_cnt_reg + 2'd1;
                end
                if (step_last)
                begin
                    state_next = stgr_pkg::ST_FLUSH;
                end
            end

            stgr_pkg::ST_FLUSH:
            begin
                ram_we          = pend_valid_reg;
                pend_valid_next = 1'b0;
                state_next      = stgr_pkg::ST_RESULT;
            end

            stgr_pkg::ST_RDWAIT:
            begin
                res_byte_next = ram_rdata;
                state_next    = stgr_pkg::ST_RESULT;
            end

            stgr_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = stgr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stgr_pkg::ST_IDLE;
            end
        endcase
    end

    // result register, cleared on a transfer unless refilled
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next                = 1'b1;
            out_data_next.read_byte       = res_byte_reg;
            out_data_next.request_ignored = res_ign_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stgr_pkg::ST_INIT;
            ready_reg      <= 1'b0;
            clr_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
            pg_cnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            col_cnt_reg    <= col_cnt_next;
            pg_cnt_reg     <= pg_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                ready_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        x0_reg        <= x0_next;
        ybase_reg     <= ybase_next;
        yoff_reg      <= yoff_next;
        font_reg      <= font_next;
        pend_addr_reg <= pend_addr_next;
        pend_mask_reg <= pend_mask_next;
        res_byte_reg  <= res_byte_next;
        res_ign_reg   <= res_ign_next;
        out_data_reg  <= out_data_next;
    end

endmodule

FILE: design/stgr_checker.sv
// port-level checker for the glyph renderer, bound to the top level
// depends on stgr_pkg and scaled_text_glyph_renderer_core_defines.svh
`include "scaled_text_glyph_renderer_core_defines.svh"

module stgr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input stgr_pkg::out_t out_data
);

    // a stalled result holds until its transfer
    `STGR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // one item at a time: the input stalls right after a transfer
    `STGR_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "input taken while busy")

    // an ignored request never carries store data
    `STGR_ASSERT_SAME(a_ignored_zero, out_valid && out_data.request_ignored, out_data.read_byte == 8'd0, "ignored request returned data")

endmodule

bind scaled_text_glyph_renderer_core stgr_checker u_stgr_checker (.*);
